### rtl/salc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache model package
// Shared types and constants for the set-associative LRU tag array model.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int TAG_W  = 63;
    localparam int ADDR_W = 64;
    localparam int CNT_W  = 32;
    localparam int REG_W  = 4;

    // Access kinds.
    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_STORE  = 2'd1,
        FUNC_MODIFY = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_WAYS_USED  = 2'd1;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_OUT
    } state_t;

    // Per-access outcome from the lookup unit.
    typedef struct packed {
        logic hit;
        logic evict;
    } outcome_t;

endpackage

### rtl/set_assoc_lru_cache_model.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative LRU cache model, top level
// An accepted beat's set is read at acceptance; in the lookup state the set is
// compared and written back and the result registered, and the result is then
// offered until taken. No new input beat is taken until that result has left.
// The set memory's read, compare and write-back bound the rate.
// Reset clears valid bits of all sets from a per-set flag register, the
// totals and the registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model import salc_pkg::*; #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [REG_W-1:0] cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,   // func
    input  logic [ADDR_W-1:0] s_tdata, // address
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_count[1:0], miss_flag[2], eviction_flag[3], total_hits[35:4],
    // total_misses[67:36], total_evictions[99:68], zero fill[103:100]
    output logic [103:0] m_tdata
);

    localparam int SETS   = 1 << MAX_SET_BITS;
    localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYS_W = $clog2(MAX_WAYS + 1);
    localparam int SET_W  = MAX_SET_BITS;

    // Configuration registers.
    logic [REG_W-1:0] set_bits_reg, ways_used_reg, block_bits_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= REG_W'(4);
            ways_used_reg  <= REG_W'(1);
            block_bits_reg <= REG_W'(4);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SET_BITS:   set_bits_reg   <= cfg_data;
                REG_WAYS_USED:  ways_used_reg  <= cfg_data;
                REG_BLOCK_BITS: block_bits_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped settings.
    logic [REG_W-1:0]  s_eff, b_eff;
    logic [WAYS_W-1:0] e_eff;
    always_comb begin
        s_eff = (set_bits_reg == '0) ? REG_W'(1) :
                (32'(set_bits_reg) > MAX_SET_BITS) ? REG_W'(MAX_SET_BITS) : set_bits_reg;
        e_eff = (ways_used_reg == '0) ? WAYS_W'(1) :
                (32'(ways_used_reg) > MAX_WAYS) ? WAYS_W'(MAX_WAYS) : WAYS_W'(ways_used_reg);
        b_eff = (block_bits_reg == '0) ? REG_W'(1) : block_bits_reg;
    end

    // Address split at acceptance.
    logic [ADDR_W-1:0] shifted;
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag_in;
    logic [ADDR_W-1:0] tag_full;
    always_comb begin
        shifted  = s_tdata >> b_eff;
        set_idx  = SET_W'(shifted) & SET_W'((1 << s_eff) - 1);
        tag_full = shifted >> s_eff;
        tag_in   = tag_full[TAG_W-1:0];
    end

    // Sequencer.
    state_t state_reg, state_next;
    logic   accept;
    assign accept = s_tvalid && s_tready;
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_OUT;
            ST_OUT:    if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Held item.
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [1:0]       func_reg;
    always_ff @(posedge aclk) begin
        if (accept) begin
            set_reg  <= set_idx;
            tag_reg  <= tag_in;
            func_reg <= s_tuser;
        end
    end

    // Set memories: tags, and per-way valid bit with age, read into registers on acceptance.
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [SETS];
    logic [MAX_WAYS-1:0][AGE_W:0]   way_mem [SETS];
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag_rd_reg;
    logic [MAX_WAYS-1:0][AGE_W:0]   way_rd_reg;
    logic [MAX_WAYS-1:0][AGE_W-1:0] age_rd;
    logic [MAX_WAYS-1:0]            vld_rd;
    logic [MAX_WAYS-1:0][AGE_W:0]   way_new;
    logic [SETS-1:0]                set_live_reg;
    logic                           live_rd_reg;

    logic [MAX_WAYS-1:0]            valid_new;
    logic [MAX_WAYS-1:0][AGE_W-1:0] age_new;
    logic [MAX_WAYS-1:0]            tag_we;
    outcome_t                       outcome;
    logic                           wb;
    assign wb = (state_reg == ST_LOOKUP) && (func_reg != FUNC_NONE);

    // The valid bit sits above the age in each way's state word.
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            age_rd[w]  = way_rd_reg[w][AGE_W-1:0];
            vld_rd[w]  = way_rd_reg[w][AGE_W];
            way_new[w] = {valid_new[w], age_new[w]};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tag_rd_reg <= tag_mem[set_idx];
            way_rd_reg <= way_mem[set_idx];
        end
        if (wb) begin
            way_mem[set_reg] <= way_new;
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (tag_we[w]) tag_mem[set_reg][w] <= tag_reg;
            end
        end
    end

    // A set never written since reset reads as empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_live_reg <= '0;
            live_rd_reg  <= 1'b0;
        end else begin
            if (accept) live_rd_reg <= set_live_reg[set_idx];
            if (wb)     set_live_reg[set_reg] <= 1'b1;
        end
    end

    salc_lookup #(.MAX_WAYS(MAX_WAYS), .AGE_W(AGE_W)) u_lookup (
        .tag       (tag_reg),
        .ways      (e_eff),
        .valid_in  (live_rd_reg ? vld_rd : '0),
        .age_in    (live_rd_reg ? age_rd : '0),
        .tag_in    (tag_rd_reg),
        .valid_out (valid_new),
        .age_out   (age_new),
        .tag_we    (tag_we),
        .outcome   (outcome)
    );

    // Counts and totals.
    logic [1:0]       hit_cnt_reg;
    logic             miss_reg, evict_reg;
    logic [CNT_W-1:0] hits_tot_reg, miss_tot_reg, evict_tot_reg;
    logic [1:0]       hit_cnt_next;
    always_comb begin
        hit_cnt_next = 2'd0;
        if (wb) begin
            hit_cnt_next = {1'b0, outcome.hit}
                         + ((func_reg == FUNC_MODIFY) ? 2'd1 : 2'd0);
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hits_tot_reg  <= '0;
            miss_tot_reg  <= '0;
            evict_tot_reg <= '0;
        end else if (state_reg == ST_LOOKUP) begin
            hits_tot_reg  <= hits_tot_reg + CNT_W'(hit_cnt_next);
            miss_tot_reg  <= miss_tot_reg + CNT_W'(wb && !outcome.hit);
            evict_tot_reg <= evict_tot_reg + CNT_W'(wb && outcome.evict);
        end
    end
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOOKUP) begin
            hit_cnt_reg <= hit_cnt_next;
            miss_reg    <= wb && !outcome.hit;
            evict_reg   <= wb && outcome.evict;
        end
    end

    assign m_tdata = {4'b0, evict_tot_reg, miss_tot_reg, hits_tot_reg,
                      evict_reg, miss_reg, hit_cnt_reg};

    // Checks.
    ap_no_hit_and_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[1:0] == 2'd2)) else $error("hit and miss");
    ap_evict_needs_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[2]) else $error("evict without miss");
    ap_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> ##1 m_tvalid) else $error("late result");

endmodule

### rtl/salc_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set lookup
// Compares one set's ways against a tag, picks the victim and builds the
// updated way contents (valid, age, write enable for the tag).
// ----------------------------------------------------------------------------
module salc_lookup import salc_pkg::*; #(
    parameter int MAX_WAYS = 8,
    parameter int AGE_W    = 3
) (
    input  logic [TAG_W-1:0]            tag,
    input  logic [$clog2(MAX_WAYS+1)-1:0] ways,
    input  logic [MAX_WAYS-1:0]         valid_in,
    input  logic [MAX_WAYS-1:0][AGE_W-1:0] age_in,
    input  logic [MAX_WAYS-1:0][TAG_W-1:0] tag_in,
    output logic [MAX_WAYS-1:0]         valid_out,
    output logic [MAX_WAYS-1:0][AGE_W-1:0] age_out,
    output logic [MAX_WAYS-1:0]         tag_we,
    output outcome_t                    outcome
);

    localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(MAX_WAYS - 1);

    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] match;
    logic                hit;
    logic                have_free;
    logic [$clog2(MAX_WAYS)-1:0] hit_way;
    logic [$clog2(MAX_WAYS)-1:0] free_way;
    logic [$clog2(MAX_WAYS)-1:0] lru_way;
    logic [$clog2(MAX_WAYS)-1:0] sel_way;
    logic [AGE_W:0]              limit;

    // Tag compare and way selection.
    always_comb begin
        hit       = 1'b0;
        have_free = 1'b0;
        hit_way   = '0;
        free_way  = '0;
        lru_way   = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = (w < ways);
            match[w]  = in_use[w] && valid_in[w] && (tag_in[w] == tag);
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit     = 1'b1;
                hit_way = w[$clog2(MAX_WAYS)-1:0];
            end
            if (in_use[w] && !valid_in[w]) begin
                have_free = 1'b1;
                free_way  = w[$clog2(MAX_WAYS)-1:0];
            end
        end
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (in_use[w] && age_in[w] > age_in[lru_way]) begin
                lru_way = w[$clog2(MAX_WAYS)-1:0];
            end
        end
    end

    // Aging of the other ways and refresh of the selected way.
    always_comb begin
        if (hit) begin
            sel_way = hit_way;
            limit   = {1'b0, age_in[hit_way]};
        end else if (have_free) begin
            sel_way = free_way;
            limit   = {1'b1, {AGE_W{1'b0}}};
        end else begin
            sel_way = lru_way;
            limit   = {1'b0, age_in[lru_way]};
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            valid_out[w] = valid_in[w];
            age_out[w]   = age_in[w];
            tag_we[w]    = 1'b0;
            if (w == sel_way) begin
                valid_out[w] = 1'b1;
                age_out[w]   = '0;
                tag_we[w]    = !hit;
            end else if (in_use[w] && valid_in[w] && ({1'b0, age_in[w]} < limit)
                         && age_in[w] < AGE_TOP) begin
                age_out[w] = age_in[w] + AGE_W'(1);
            end
        end
        outcome.hit   = hit;
        outcome.evict = !hit && !have_free;
    end

endmodule
